// File: rtl/cmta_pkg.sv
// Package with shared types, constants and helpers for the cube-map texel address block.
package cmta_pkg;

    localparam int MAX_EXTENT = 4096;
    localparam int MAX_LAYERS = 64;
    localparam int EXT_W      = 13;
    localparam int TEX_W      = 12;
    localparam int QDEPTH     = 2;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_FACE  = 3'd1,
        ST_BAD_WIDTH = 3'd2,
        ST_OOB       = 3'd3,
        ST_WRONG     = 3'd4,
        ST_ZERO_DIR  = 3'd5
    } status_t;

    localparam logic [1:0] REQ_COORD = 2'd0;
    localparam logic [1:0] REQ_2D    = 2'd1;
    localparam logic [1:0] REQ_CUBE  = 2'd2;

    localparam logic [1:0] KIND_2D   = 2'd0;
    localparam logic [1:0] KIND_CUBE = 2'd1;

    localparam logic [2:0] CFG_KIND  = 3'd0;
    localparam logic [2:0] CFG_EX    = 3'd1;
    localparam logic [2:0] CFG_EY    = 3'd2;
    localparam logic [2:0] CFG_EZ    = 3'd3;
    localparam logic [2:0] CFG_LAYER = 3'd4;
    localparam logic [2:0] CFG_COMP  = 3'd5;
    localparam logic [2:0] CFG_CBYTE = 3'd6;
    localparam logic [2:0] CFG_DATA  = 3'd7;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] coord_a;
        logic signed [31:0] coord_b;
        logic signed [31:0] coord_c;
        logic [5:0]         face_in;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  face;
        logic [11:0] texel_x;
        logic [11:0] texel_y;
        logic [11:0] texel_z;
        logic [31:0] byte_offset;
    } rsp_t;

    // Classified item passed from front to back.
    typedef struct packed {
        logic [2:0]  status;
        logic        cube;
        logic [5:0]  face;
        logic [16:0] fx;
        logic [16:0] fy;
        logic [16:0] fz;
    } cls_t;

    // Clamp an extent register to 1..MAX_EXTENT, minus one.
    function automatic logic [EXT_W-1:0] ext_m1(input logic [EXT_W-1:0] r);
        logic [EXT_W-1:0] e;
        begin
            e = r;
            if (r == '0)
                e = EXT_W'(1);
            else if (r > EXT_W'(MAX_EXTENT))
                e = EXT_W'(MAX_EXTENT);
            ext_m1 = e - EXT_W'(1);
        end
    endfunction

    function automatic logic [16:0] frac16(input logic signed [31:0] q);
        logic [31:0] m;
        begin
            m = q[31] ? 32'(-q) : 32'(q);
            frac16 = {1'b0, m[15:0]};
        end
    endfunction

endpackage

// File: rtl/cmta_div.sv
// Pipelined restoring divider for cube face coordinates: 17-bit quotient of num / den.
module cmta_div
    import cmta_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [48:0] num,
    input  logic [32:0] den,
    output logic [16:0] quo
);
    // num < 2^17 * den whenever den is nonzero, so the quotient fits 17 bits and num >> 20 is below den.
    // Twenty quotient bits are developed, four a stage over five stages.
    localparam int NST = 5;
    localparam int BPS = 4;
    localparam int QW  = NST * BPS;
    logic [33:0]   rem_reg  [NST];
    logic [QW-1:0] num_reg  [NST];
    logic [32:0]   den_reg  [NST];
    logic [QW-1:0] q_reg    [NST];
    logic [33:0]   rem_in   [NST];
    logic [QW-1:0] num_in   [NST];
    logic [32:0]   den_in   [NST];
    logic [QW-1:0] q_in     [NST];
    logic [33:0]   rem_next [NST];
    logic [QW-1:0] num_next [NST];
    logic [QW-1:0] q_next   [NST];

    always_comb
    begin
        rem_in[0] = 34'(num[48:QW]);
        num_in[0] = num[QW-1:0];
        den_in[0] = den;
        q_in[0]   = '0;
        for (int s = 1; s < NST; s++) begin
            rem_in[s] = rem_reg[s-1];
            num_in[s] = num_reg[s-1];
            den_in[s] = den_reg[s-1];
            q_in[s]   = q_reg[s-1];
        end
    end

    always_comb
    begin
        logic [33:0]   r;
        logic [QW-1:0] n;
        logic [QW-1:0] q;
        for (int s = 0; s < NST; s++) begin
            r = rem_in[s];
            n = num_in[s];
            q = q_in[s];
            for (int k = 0; k < BPS; k++) begin
                r = {r[32:0], n[QW-1]};
                n = {n[QW-2:0], 1'b0};
                q = {q[QW-2:0], 1'b0};
                if (r >= {1'b0, den_in[s]}) begin
                    r = r - {1'b0, den_in[s]};
                    q[0] = 1'b1;
                end
            end
            rem_next[s] = r;
            num_next[s] = n;
            q_next[s]   = q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            for (int s = 0; s < NST; s++) begin
                rem_reg[s] <= rem_next[s];
                num_reg[s] <= num_next[s];
                den_reg[s] <= den_in[s];
                q_reg[s]   <= q_next[s];
            end
        end
    end

    assign quo = q_reg[NST-1][16:0];
endmodule

// File: rtl/cmta_front.sv
// Front end: checks request kind, picks the cube face and computes face coordinates.
module cmta_front
    import cmta_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  req_t       in_data,
    input  logic [1:0] texture_kind,
    output logic       cls_valid,
    input  logic       cls_ready,
    output cls_t       cls_data
);
    localparam int LAT = 6;  // face select register plus five divider stages

    logic [LAT-1:0] vld_reg;
    cls_t           pipe_reg [LAT];
    logic           adv;
    logic [48:0]    nu_next, nv_next;
    logic [32:0]    den_next;
    logic [48:0]    nu_reg, nv_reg;
    logic [32:0]    den_reg;
    logic [16:0]    qu, qv;
    cls_t           c_next;

    assign adv       = !vld_reg[LAT-1] || cls_ready;
    assign in_ready  = adv;
    assign cls_valid = vld_reg[LAT-1];

    always_comb
    begin
        logic [32:0] ax, ay, az, m;
        logic signed [33:0] u, v;
        logic signed [33:0] a, b, c;
        a = 34'(in_data.coord_a);
        b = 34'(in_data.coord_b);
        c = 34'(in_data.coord_c);
        ax = a[33] ? 33'(-a) : 33'(a);
        ay = b[33] ? 33'(-b) : 33'(b);
        az = c[33] ? 33'(-c) : 33'(c);
        c_next = '0;
        m = '0; u = '0; v = '0;
        case (in_data.req_type)
            REQ_COORD:
            begin
                c_next.face = in_data.face_in;
                c_next.fx = frac16(in_data.coord_a);
                c_next.fy = frac16(in_data.coord_b);
                c_next.fz = frac16(in_data.coord_c);
            end
            REQ_2D:
            begin
                if (texture_kind != KIND_2D)
                    c_next.status = ST_WRONG;
                c_next.fx = frac16(in_data.coord_a);
                c_next.fy = frac16(in_data.coord_b);
            end
            REQ_CUBE:
            begin
                c_next.cube = 1'b1;
                if (texture_kind != KIND_CUBE)
                    c_next.status = ST_WRONG;
                if (az >= ax && az >= ay) begin
                    m = az;
                    if (c[33]) begin
                        c_next.face = 6'd5; u = -a; v = -b;
                    end else begin
                        c_next.face = 6'd4; u = a; v = -b;
                    end
                end else if (ay >= ax) begin
                    m = ay;
                    if (b[33]) begin
                        c_next.face = 6'd3; u = a; v = -c;
                    end else begin
                        c_next.face = 6'd2; u = a; v = c;
                    end
                end else begin
                    m = ax;
                    if (a[33]) begin
                        c_next.face = 6'd1; u = c; v = -b;
                    end else begin
                        c_next.face = 6'd0; u = -c; v = -b;
                    end
                end
                if (c_next.status == ST_OK && m == '0)
                    c_next.status = ST_ZERO_DIR;
            end
            default: c_next.status = ST_WRONG;
        endcase
        // u + m lies in 0..2m, which needs all 33 bits.
        nu_next  = {33'(u + 34'(m)), 16'd0} + 49'(m);
        nv_next  = {33'(v + 34'(m)), 16'd0} + 49'(m);
        den_next = {m[31:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            pipe_reg[0] <= c_next;
            for (int i = 1; i < LAT; i++)
                pipe_reg[i] <= pipe_reg[i-1];
            nu_reg  <= nu_next;
            nv_reg  <= nv_next;
            den_reg <= den_next;
        end
    end

    cmta_div u_div_u (.clk, .en(adv), .num(nu_reg), .den(den_reg), .quo(qu));
    cmta_div u_div_v (.clk, .en(adv), .num(nv_reg), .den(den_reg), .quo(qv));

    always_comb
    begin
        cls_data = pipe_reg[LAT-1];
        if (pipe_reg[LAT-1].cube) begin
            cls_data.fx = qu;
            cls_data.fy = qv;
            cls_data.fz = '0;
        end
    end
endmodule

// File: rtl/cmta_fifo.sv
// Small queue between the front and back ends.
module cmta_fifo
    import cmta_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  cls_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output cls_t rd_data
);
    cls_t        mem_reg [QDEPTH];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;
    logic        wr, rd;

    assign wr_ready = cnt_reg != 2'(QDEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end
endmodule

// File: rtl/cmta_back.sv
// Back end: texel rounding, byte offset and the remaining status checks.
module cmta_back
    import cmta_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cls_valid,
    output logic        cls_ready,
    input  cls_t        cls_data,
    input  logic [12:0] extent_x,
    input  logic [12:0] extent_y,
    input  logic [12:0] extent_z,
    input  logic [6:0]  layer_count,
    input  logic [2:0]  components,
    input  logic [2:0]  component_bytes,
    input  logic [31:0] data_bytes,
    output logic        out_valid,
    input  logic        out_ready,
    output rsp_t        out_data
);
    // Stages: 0 texel scale and layer/width checks, 1 face*Ez+z, 2 *Ey+y, 3 *Ex+x,
    // 4 *components, 5 bounds check and clearing of failed results.
    localparam int NS = 6;
    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  face;
        logic [11:0] tx, ty, tz;
        logic [44:0] acc;
    } bst_t;

    logic [NS-1:0] vld_reg;
    bst_t          st_reg  [NS];
    bst_t          st_next [NS];
    logic          adv;
    logic [12:0]   mx, my, mz;
    logic [12:0]   ex, ey, ez;
    logic [27:0]   px, py, pz;

    assign adv       = !vld_reg[NS-1] || out_ready;
    assign cls_ready = adv;
    assign out_valid = vld_reg[NS-1];

    assign mx = ext_m1(extent_x);
    assign my = ext_m1(extent_y);
    assign mz = ext_m1(extent_z);
    assign ex = mx + 13'd1;
    assign ey = my + 13'd1;
    assign ez = mz + 13'd1;
    // A fraction of at most 1.0 times at most 4095 stays below 2^28, so texels fit 12 bits.
    assign px = 28'(cls_data.fx) * 28'(mx) + 28'h8000;
    assign py = 28'(cls_data.fy) * 28'(my) + 28'h8000;
    assign pz = 28'(cls_data.fz) * 28'(mz) + 28'h8000;

    always_comb
    begin
        logic [17:0] a1;
        logic [29:0] a2;
        logic [41:0] a3;
        logic [44:0] a4;
        logic [45:0] need;

        st_next[0] = '0;
        st_next[0].status = cls_data.status;
        st_next[0].face   = cls_data.face;
        st_next[0].tx     = px[27:16];
        st_next[0].ty     = py[27:16];
        st_next[0].tz     = pz[27:16];
        if (cls_data.status == ST_OK) begin
            if ({1'b0, cls_data.face} >= layer_count)
                st_next[0].status = ST_BAD_FACE;
            else if (component_bytes != 3'd1)
                st_next[0].status = ST_BAD_WIDTH;
        end

        a1 = 18'(st_reg[0].face) * 18'(ez) + 18'(st_reg[0].tz);
        st_next[1] = st_reg[0];
        st_next[1].acc = 45'(a1);

        a2 = 30'(st_reg[1].acc[17:0]) * 30'(ey) + 30'(st_reg[1].ty);
        st_next[2] = st_reg[1];
        st_next[2].acc = 45'(a2);

        a3 = 42'(st_reg[2].acc[29:0]) * 42'(ex) + 42'(st_reg[2].tx);
        st_next[3] = st_reg[2];
        st_next[3].acc = 45'(a3);

        a4 = 45'(st_reg[3].acc[41:0]) * 45'(components);
        st_next[4] = st_reg[3];
        st_next[4].acc = a4;

        // The texel must end inside the data: index + components <= data_bytes.
        need = 46'(st_reg[4].acc) + 46'(components);
        st_next[5] = st_reg[4];
        if (st_reg[4].status == ST_OK && need > 46'(data_bytes))
            st_next[5].status = ST_OOB;
        if (st_next[5].status != ST_OK) begin
            st_next[5].face = '0;
            st_next[5].tx   = '0;
            st_next[5].ty   = '0;
            st_next[5].tz   = '0;
            st_next[5].acc  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NS-2:0], cls_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            for (int i = 0; i < NS; i++)
                st_reg[i] <= st_next[i];
        end
    end

    always_comb
    begin
        out_data.status      = st_reg[NS-1].status;
        out_data.face        = st_reg[NS-1].face;
        out_data.texel_x     = st_reg[NS-1].tx;
        out_data.texel_y     = st_reg[NS-1].ty;
        out_data.texel_z     = st_reg[NS-1].tz;
        out_data.byte_offset = st_reg[NS-1].acc[31:0];
    end
endmodule

// File: rtl/cube_map_texel_address_top.sv
// Top level of the cube-map texel address generator.
//   channel | signals                               | direction
//   request | req_valid, req_ready, req_data        | in
//   result  | rsp_valid, rsp_ready, rsp_data        | out
//   config  | cfg_we, cfg_index, cfg_data           | in
// One beat is accepted per cycle while nothing stalls. An accepted request passes through
// six front stages (face select plus a five-stage divider), one queue slot and six back
// stages before it is offered on the result side.
// Reset (rst_n, asynchronous) restores the register reset values and empties all stages.
// A stall on the result side freezes the back pipeline, fills the two-entry queue and
// then freezes the front pipeline, which drops req_ready.
module cube_map_texel_address_top
    import cmta_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_t        req_data,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output rsp_t        rsp_data,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    logic [1:0]  kind_reg;
    logic [12:0] ex_reg, ey_reg, ez_reg;
    logic [6:0]  layer_reg;
    logic [2:0]  comp_reg, cbyte_reg;
    logic [31:0] data_reg;
    logic        f_valid, f_ready, q_valid, q_ready;
    cls_t        f_data, q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            kind_reg  <= KIND_2D;
            ex_reg    <= 13'd1;
            ey_reg    <= 13'd1;
            ez_reg    <= 13'd1;
            layer_reg <= 7'd1;
            comp_reg  <= 3'd4;
            cbyte_reg <= 3'd1;
            data_reg  <= 32'd4;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_KIND:  kind_reg  <= cfg_data[1:0];
                CFG_EX:    ex_reg    <= cfg_data[12:0];
                CFG_EY:    ey_reg    <= cfg_data[12:0];
                CFG_EZ:    ez_reg    <= cfg_data[12:0];
                CFG_LAYER: layer_reg <= cfg_data[6:0];
                CFG_COMP:  comp_reg  <= cfg_data[2:0];
                CFG_CBYTE: cbyte_reg <= cfg_data[2:0];
                CFG_DATA:  data_reg  <= cfg_data;
                default:   data_reg  <= data_reg;
            endcase
        end
    end

    cmta_front u_front (
        .clk, .rst_n, .in_valid(req_valid), .in_ready(req_ready), .in_data(req_data),
        .texture_kind(kind_reg), .cls_valid(f_valid), .cls_ready(f_ready), .cls_data(f_data)
    );

    cmta_fifo u_fifo (
        .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
    );

    cmta_back u_back (
        .clk, .rst_n, .cls_valid(q_valid), .cls_ready(q_ready), .cls_data(q_data),
        .extent_x(ex_reg), .extent_y(ey_reg), .extent_z(ez_reg), .layer_count(layer_reg),
        .components(comp_reg), .component_bytes(cbyte_reg), .data_bytes(data_reg),
        .out_valid(rsp_valid), .out_ready(rsp_ready), .out_data(rsp_data)
    );
endmodule
